// ===== src/jswg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jswg_pkg: shared types, codes and constants of the joint setpoint generator
// Holds the channel word types, the opcode and register index codes, the
// datapath widths and the elaboration-time sine table builder.
// ----------------------------------------------------------------------------
package jswg_pkg;

    // default sizes
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int COUNT_W_DEF    = 16;

    // input function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // wave modes
    localparam logic [1:0] WAVE_MANUAL = 2'd0;
    localparam logic [1:0] WAVE_SINE   = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;
    localparam logic [1:0] WAVE_RAMP   = 2'd3;

    // joint work modes, also the command kind
    localparam logic [1:0] WORK_PWM      = 2'd0;
    localparam logic [1:0] WORK_CURRENT  = 2'd1;
    localparam logic [1:0] WORK_SPEED    = 2'd2;
    localparam logic [1:0] WORK_POSITION = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORK_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd7;

    // register reset values
    localparam logic [15:0] PERIOD_RST = 16'd67;
    localparam logic [15:0] HALF_RST   = 16'd34;
    localparam logic [15:0] STEP_RST   = 16'd983;
    localparam logic [15:0] RATIO_RST  = 16'd1;

    // datapath widths
    localparam int SIN_W    = 17;   // q15 sine, +-32768
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int PHASE_W  = 48;   // widest count times 16-bit step
    localparam int WAVE_W   = 50;
    localparam int DIV_W    = 64;
    localparam int DIV_STEP_BITS = 8;
    localparam int DIV_REM_W = 6;

    // speed: *65536/60 = *16384/15, position: *65536/360 = *8192/45
    localparam logic [DIV_REM_W-1:0] SPEED_DIV = 6'd15;
    localparam logic [DIV_REM_W-1:0] POS_DIV   = 6'd45;
    localparam int SPEED_SHIFT = 14;
    localparam int POS_SHIFT   = 13;

    // channel words
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] measured_position;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] command_value;
        logic [1:0]         command_kind;
    } t_out_word;

    // constant divider handshake
    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] divisor;
        logic [DIV_W-1:0]     dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    // quarter-wave sine in q30, angle f in q16 turns (0..16384)
    function automatic logic [63:0] quarter_sine(input logic [63:0] f);
        logic [63:0] u;
        logic [63:0] r2;
        logic [63:0] p;
        logic [63:0] one;
        one = 64'd1 << 30;
        u   = f * 64'd102944;
        r2  = (u * u) >> 30;
        p   = one - r2 / 64'd72;
        p   = one - ((r2 * p) >> 30) / 64'd42;
        p   = one - ((r2 * p) >> 30) / 64'd20;
        p   = one - ((r2 * p) >> 30) / 64'd6;
        return (u * p) >> 30;
    endfunction

    // table entry for a q16 turn fraction, rounded to q15
    function automatic logic signed [SIN_W-1:0] sine_q15(input logic [31:0] a);
        logic [1:0]  q;
        logic [63:0] f;
        logic [63:0] s;
        q = a[15:14];
        f = {50'd0, a[13:0]};
        if (q[0]) begin
            f = 64'd16384 - f;
        end
        s = (quarter_sine(f) + 64'd16384) >> 15;
        if (s > 64'd32768) begin
            s = 64'd32768;
        end
        return q[1] ? -$signed(SIN_W'(s)) : $signed(SIN_W'(s));
    endfunction

endpackage

// ===== src/jswg_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jswg_sine_rom: sine lookup table
// Constant q15 sine table over one full turn, built at elaboration, with a
// registered read port.
// ----------------------------------------------------------------------------
module jswg_sine_rom
    import jswg_pkg::*;
#(
    parameter int  DEPTH = SINE_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic [AW-1:0]           i_addr,
    output logic signed [SIN_W-1:0] o_data
);

    logic signed [SIN_W-1:0] w_tab [DEPTH];
    logic signed [SIN_W-1:0] r_data;

    // entry k holds the sine of floor(k*65536/depth) q16 turns
    for (genvar k = 0; k < DEPTH; k++) begin : g_tab
        assign w_tab[k] = sine_q15(32'((k * 65536) / DEPTH));
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== src/jswg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jswg_mul: shared signed multiplier
// One 33 x 18 signed multiplier with a registered product, time-shared by
// every multiplication of the sequencer.
// ----------------------------------------------------------------------------
module jswg_mul
    import jswg_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] w_a;
    logic signed [MUL_P_W-1:0] w_b;
    logic signed [MUL_P_W-1:0] r_p;

    // sign extend both operands to the product width
    assign w_a = MUL_P_W'(i_a);
    assign w_b = MUL_P_W'(i_b);

    // registered product
    always_ff @(posedge i_clk) begin
        r_p <= w_a * w_b;
    end

    assign o_p = r_p;

endmodule

// ===== src/jswg_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jswg_cdiv: divider by a small constant
// Unsigned restoring division of a 64-bit magnitude by a 6-bit divisor,
// eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module jswg_cdiv
    import jswg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = DIV_W / DIV_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_REM_W-1:0] r_div;

    logic [DIV_W-1:0]     w_num;
    logic [DIV_REM_W-1:0] w_rem;
    logic [DIV_REM_W:0]   w_trial;

    // eight restoring steps; quotient bits shift in behind the dividend
    always_comb begin
        w_num   = r_num;
        w_rem   = r_rem;
        w_trial = '0;
        for (int j = 0; j < DIV_STEP_BITS; j++) begin
            w_trial = {w_rem, w_num[DIV_W-1]};
            if (w_trial >= {1'b0, r_div}) begin
                w_rem = DIV_REM_W'(w_trial - {1'b0, r_div});
                w_num = {w_num[DIV_W-2:0], 1'b1};
            end else begin
                w_rem = w_trial[DIV_REM_W-1:0];
                w_num = {w_num[DIV_W-2:0], 1'b0};
            end
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend, remainder and divisor
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= w_num;
            r_rem <= w_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule

// ===== src/joint_setpoint_wave_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_setpoint_wave_generator_top: tick-driven joint setpoint generator
// Makes manual, square, sawtooth and sine setpoints and scales them to the
// joint's work mode, under a small sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_word) takes a tick, a
//   start or a stop word. The output channel (o_out_valid / i_out_ready /
//   o_out_word) gives at most one command word per input word. Registers
//   are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Sequencing:
//   start, stop when not running and ticks that give no command leave the
//   sequencer idle. A stop command goes from idle straight to the emit step.
//   A tick command passes the phase and multiply steps (ramp, sine only),
//   then the saturate and scale steps in pwm and current mode; speed and
//   position mode add the constant divider, and speed one more multiply.
//   The sequencer holds one word at a time, so it takes a new word only
//   once done with the last, set by the passes through the shared 33 x 18
//   multiplier and the 8-bit-per-cycle divider.
// Reset:
//   synchronous, clears the counters, the run flag and the square phase and
//   loads the register defaults; the sine table is a constant, no fill pass.
// Stall:
//   a finished command waits in the output register; the next word is
//   accepted meanwhile, and a new command waits until that register frees.
// ----------------------------------------------------------------------------
module joint_setpoint_wave_generator_top
    import jswg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int COUNT_WIDTH      = COUNT_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW         = COUNT_WIDTH;
    localparam int CMP_W      = (CW > 16) ? CW : 16;
    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_PROD_W = 16 + IDX_W + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PH    = 4'd1;
    localparam logic [3:0] S_ROM   = 4'd2;
    localparam logic [3:0] S_SMUL  = 4'd3;
    localparam logic [3:0] S_SFIN  = 4'd4;
    localparam logic [3:0] S_RLO   = 4'd5;
    localparam logic [3:0] S_RHI   = 4'd6;
    localparam logic [3:0] S_RFIN  = 4'd7;
    localparam logic [3:0] S_SAT   = 4'd8;
    localparam logic [3:0] S_SCALE = 4'd9;
    localparam logic [3:0] S_SPD   = 4'd10;
    localparam logic [3:0] S_DIV   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    localparam logic signed [WAVE_W-1:0] SAT_HI = WAVE_W'(64'sd2147483647);
    localparam logic signed [WAVE_W-1:0] SAT_LO = WAVE_W'(-64'sd2147483648);

    // control state
    logic [3:0]    r_state;
    logic          r_running;
    logic [CW-1:0] r_tick_cnt;
    logic [CW-1:0] r_wave_cnt;
    logic          r_sq_high;
    logic          r_out_valid;

    // configuration registers
    logic [1:0]         r_wave_mode;
    logic [1:0]         r_work_mode;
    logic signed [15:0] r_bias;
    logic [14:0]        r_amp;
    logic [15:0]        r_period;
    logic [15:0]        r_half;
    logic [15:0]        r_step;
    logic [15:0]        r_ratio;

    // datapath registers
    logic [CW-1:0]             r_wc_used;
    logic [PHASE_W-1:0]        r_phase;
    logic [46:0]               r_acc;
    logic signed [WAVE_W-1:0]  r_wave;
    logic signed [31:0]        r_v32;
    logic                      r_neg;
    logic signed [31:0]        r_res;
    t_out_word                 r_out_word;

    // shared units
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_p;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;
    logic signed [SIN_W-1:0]   w_sin;
    logic [IDX_PROD_W-1:0]     w_idx_prod;
    logic [IDX_W-1:0]          w_idx;

    // tick datapath
    logic                      w_accept;
    logic [CW-1:0]             w_tc_inc;
    logic [CW-1:0]             w_wc_inc;
    logic                      w_half_hit;
    logic                      w_period_hit;
    logic signed [16:0]        w_sq_val;
    logic [62:0]               w_ramp_prod;
    logic signed [WAVE_W-1:0]  w_ramp_sum;
    logic signed [WAVE_W-1:0]  w_ramp_val;
    logic signed [33:0]        w_sin_n;
    logic signed [33:0]        w_sin_q;
    logic signed [WAVE_W-1:0]  w_sat;
    logic [31:0]               w_v32_abs;
    logic signed [MUL_P_W-1:0] w_p_abs;
    logic [31:0]               w_quot_sat;
    logic                      w_emit_free;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_emit_free = !r_out_valid || i_out_ready;

    // counters
    assign w_tc_inc     = r_tick_cnt + 1'b1;
    assign w_wc_inc     = r_wave_cnt + 1'b1;
    assign w_half_hit   = CMP_W'(w_tc_inc) >= CMP_W'(r_half);
    assign w_period_hit = CMP_W'(w_wc_inc) >= CMP_W'(r_period);

    // square level around the bias, after the flip
    assign w_sq_val = r_sq_high ? (17'(r_bias) - $signed({2'b00, r_amp}))
                                : (17'(r_bias) + $signed({2'b00, r_amp}));

    // ramp: amplitude times phase in q16, truncated toward zero with the bias
    assign w_ramp_prod = {16'd0, r_acc} + {w_p[30:0], 32'd0};
    assign w_ramp_sum  = $signed({3'b000, w_ramp_prod[62:16]}) + WAVE_W'(r_bias);
    assign w_ramp_val  = (w_ramp_sum < 0 && (w_ramp_prod[15:0] != 16'd0))
                       ? w_ramp_sum + WAVE_W'(1) : w_ramp_sum;

    // sine: table times amplitude plus bias in q15, truncated toward zero
    assign w_sin_n = $signed(w_p[33:0]) + $signed({{3{r_bias[15]}}, r_bias, 15'd0});
    assign w_sin_q = (w_sin_n + (w_sin_n[33] ? 34'sd32767 : 34'sd0)) >>> 15;

    // table index from the low phase bits
    assign w_idx_prod = IDX_PROD_W'(w_p[15:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign w_idx      = w_idx_prod[16 +: IDX_W];

    // 32-bit saturation of the waveform value
    assign w_sat = (r_wave > SAT_HI) ? SAT_HI : ((r_wave < SAT_LO) ? SAT_LO : r_wave);

    // magnitudes for the divider
    assign w_v32_abs = r_v32[31] ? 32'(-r_v32) : 32'(r_v32);
    assign w_p_abs   = w_p[MUL_P_W-1] ? -w_p : w_p;

    // signed, saturated quotient
    always_comb begin
        if (r_neg) begin
            w_quot_sat = (w_div_rsp.quotient > 64'd2147483648) ? 32'h8000_0000
                       : 32'(-w_div_rsp.quotient);
        end else begin
            w_quot_sat = (w_div_rsp.quotient > 64'd2147483647) ? 32'h7FFF_FFFF
                       : w_div_rsp.quotient[31:0];
        end
    end

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_PH: begin
                w_mul_a = $signed(MUL_A_W'(r_wc_used));
                w_mul_b = $signed({2'b00, r_step});
            end
            S_RLO: begin
                w_mul_a = $signed({1'b0, w_p[31:0]});
                w_mul_b = $signed({3'b000, r_amp});
            end
            S_RHI: begin
                w_mul_a = $signed({17'd0, r_phase[PHASE_W-1:32]});
                w_mul_b = $signed({3'b000, r_amp});
            end
            S_SMUL: begin
                w_mul_a = MUL_A_W'(w_sin);
                w_mul_b = $signed({3'b000, r_amp});
            end
            S_SCALE: begin
                w_mul_a = MUL_A_W'(r_v32);
                w_mul_b = $signed({2'b00, r_ratio});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // divider request: position straight from the scale step, speed after
    // the ratio multiply
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.divisor  = POS_DIV;
        w_div_req.dividend = {19'd0, w_v32_abs, POS_SHIFT'(0)};
        if (r_state == S_SPD) begin
            w_div_req.start    = 1'b1;
            w_div_req.divisor  = SPEED_DIV;
            w_div_req.dividend = {2'b00, w_p_abs[47:0], SPEED_SHIFT'(0)};
        end else if (r_state == S_SCALE && r_work_mode == WORK_POSITION) begin
            w_div_req.start = 1'b1;
        end
    end

    jswg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    jswg_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    jswg_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (w_idx),
        .o_data (w_sin)
    );

    // sequencer, counters, run flag and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_tick_cnt  <= '0;
            r_wave_cnt  <= '0;
            r_sq_high   <= 1'b0;
            r_out_valid <= 1'b0;
            r_wave_mode <= WAVE_MANUAL;
            r_work_mode <= WORK_PWM;
            r_bias      <= '0;
            r_amp       <= '0;
            r_period    <= PERIOD_RST;
            r_half      <= HALF_RST;
            r_step      <= STEP_RST;
            r_ratio     <= RATIO_RST;
        end else begin
            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WAVE_MODE: r_wave_mode <= i_cfg_data[1:0];
                    REG_WORK_MODE: r_work_mode <= i_cfg_data[1:0];
                    REG_BIAS:      r_bias      <= $signed(i_cfg_data);
                    REG_AMPLITUDE: r_amp       <= i_cfg_data[14:0];
                    REG_PERIOD:    r_period    <= i_cfg_data;
                    REG_HALF:      r_half      <= i_cfg_data;
                    REG_STEP:      r_step      <= i_cfg_data;
                    REG_RATIO:     r_ratio     <= i_cfg_data;
                    default: ;
                endcase
            end

            // output register drains
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in_word.func)
                            FUNC_START: r_running <= 1'b1;
                            FUNC_STOP: begin
                                if (r_running) begin
                                    r_running <= 1'b0;
                                    r_state   <= S_EMIT;
                                end
                            end
                            FUNC_TICK: begin
                                if (r_running) begin
                                    case (r_wave_mode) inside
                                        WAVE_MANUAL: begin
                                            r_tick_cnt <= '0;
                                            r_state    <= S_SAT;
                                        end
                                        WAVE_SQUARE: begin
                                            if (w_half_hit) begin
                                                r_tick_cnt <= '0;
                                                r_sq_high  <= !r_sq_high;
                                                r_state    <= S_SAT;
                                            end else begin
                                                r_tick_cnt <= w_tc_inc;
                                            end
                                        end
                                        WAVE_SINE, WAVE_RAMP: begin
                                            r_tick_cnt <= '0;
                                            r_wave_cnt <= w_period_hit ? '0 : w_wc_inc;
                                            r_state    <= S_PH;
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PH:    r_state <= (r_wave_mode == WAVE_RAMP) ? S_RLO : S_ROM;
                S_ROM:   r_state <= S_SMUL;
                S_SMUL:  r_state <= S_SFIN;
                S_SFIN:  r_state <= S_SAT;
                S_RLO:   r_state <= S_RHI;
                S_RHI:   r_state <= S_RFIN;
                S_RFIN:  r_state <= S_SAT;
                S_SAT:   r_state <= S_SCALE;
                S_SCALE: begin
                    case (r_work_mode)
                        WORK_SPEED:    r_state <= S_SPD;
                        WORK_POSITION: r_state <= S_DIV;
                        default:       r_state <= S_EMIT;
                    endcase
                end
                S_SPD:   r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_wc_used <= w_wc_inc;
                    r_res     <= (r_work_mode == WORK_POSITION)
                               ? i_in_word.measured_position : 32'sd0;
                    r_wave    <= (r_wave_mode == WAVE_SQUARE) ? WAVE_W'(w_sq_val)
                                                              : WAVE_W'(r_bias);
                end
            end
            S_RLO:  r_phase <= w_p[PHASE_W-1:0];
            S_RHI:  r_acc   <= w_p[46:0];
            S_RFIN: r_wave  <= w_ramp_val;
            S_SFIN: r_wave  <= WAVE_W'($signed(w_sin_q[15:0]));
            S_SAT:  r_v32   <= 32'(w_sat);
            S_SCALE: begin
                r_neg <= r_v32[31];
                if (r_work_mode == WORK_PWM) begin
                    r_res <= 32'($signed(r_v32[15:0]));
                end else begin
                    r_res <= r_v32;
                end
            end
            S_SPD:  r_neg <= w_p[MUL_P_W-1];
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_res <= $signed(w_quot_sat);
                end
            end
            S_EMIT: begin
                if (w_emit_free) begin
                    r_out_word.command_value <= r_res;
                    r_out_word.command_kind  <= r_work_mode;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a word that cannot give a command leaves the sequencer idle
    a_no_work_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.func != FUNC_TICK
            && !(i_in_word.func == FUNC_STOP && r_running)) |=> o_in_ready)
        else $error("sequencer left idle on a word without a command");

    // a finished command waits while the output register is still full
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_out_ready) |=> (r_state == S_EMIT))
        else $error("command overran a full output register");

    // the divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule
